>>> rtl/dcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared widths, payload structs and pipeline sideband types for the
// distance constraint projection core.
// ----------------------------------------------------------------------------
package dcp_pkg;

    // Field widths fixed by the interface.
    localparam int POS_W     = 32;
    localparam int MASS_W    = 24;
    localparam int REST_W    = 31;
    localparam int STIFF_W   = 17;
    localparam int GAIN_W    = 17;
    localparam int GAIN_FRAC = 16;

    // Derived internal widths.
    localparam int MAG_W   = POS_W + 1;           // |a - b| per axis
    localparam int WSUM_W  = MASS_W + 1;          // sum of inverse masses
    localparam int PROD_W  = STIFF_W + MASS_W;    // stiffness times inverse mass
    localparam int SQ_W    = 2 * MAG_W;           // one squared axis and the sum
    localparam int ROOT_W  = MAG_W;               // floor(sqrt(sum))
    localparam int C_W     = ROOT_W + 1;          // signed separation error
    localparam int DELTA_W = MAG_W + GAIN_W - GAIN_FRAC;
    localparam int WIDE_W  = DELTA_W + 2;         // position plus correction

    localparam logic [STIFF_W-1:0] STIFF_RESET   = STIFF_W'(65536);
    localparam int                 FRAC_BITS_DEF = 16;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic [MAG_W-1:0]        t_mag;
    typedef logic [GAIN_W-1:0]       t_gain;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_a_x;
        logic signed [POS_W-1:0] pos_a_y;
        logic signed [POS_W-1:0] pos_a_z;
        logic signed [POS_W-1:0] pos_b_x;
        logic signed [POS_W-1:0] pos_b_y;
        logic signed [POS_W-1:0] pos_b_z;
        logic [MASS_W-1:0]       inv_mass_a;
        logic [MASS_W-1:0]       inv_mass_b;
        logic [REST_W-1:0]       rest_length;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] new_a_x;
        logic signed [POS_W-1:0] new_a_y;
        logic signed [POS_W-1:0] new_a_z;
        logic signed [POS_W-1:0] new_b_x;
        logic signed [POS_W-1:0] new_b_y;
        logic signed [POS_W-1:0] new_b_z;
    } t_out;

    // Sideband through the gain divider.
    typedef struct packed {
        t_pos [2:0]        pos_a;
        t_pos [2:0]        pos_b;
        t_mag [2:0]        dmag;
        logic [2:0]        dneg;
        logic [REST_W-1:0] rest;
        logic              fixed;
    } t_pre;

    // Sideband through the squaring stages and the square root.
    typedef struct packed {
        t_pre  pre;
        t_gain ga;
        t_gain gb;
    } t_sq;

    // Sideband through the direction divider and the correction stages.
    typedef struct packed {
        t_pos [2:0] pos_a;
        t_pos [2:0] pos_b;
        logic [2:0] dneg;
        t_mag       cmag;
        logic       cneg;
        t_gain      ga;
        t_gain      gb;
        logic       fixed;
    } t_cor;

endpackage

>>> rtl/dcp_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_div_pipe
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module dcp_div_pipe #(
    parameter int LANES = 2,
    parameter int DW    = 41,
    parameter int VW    = 25,
    parameter int QW    = 17,
    parameter int SW    = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][DW-1:0]    i_dividend,
    input  logic [VW-1:0]               i_divisor,
    input  logic [SW-1:0]               i_side,
    output logic                        o_valid,
    output logic [LANES-1:0][QW-1:0]    o_quot,
    output logic [SW-1:0]               o_side
);

    localparam int CW = (DW > VW + QW) ? DW : VW + QW;

    logic                     r_valid [1:QW];
    logic [LANES-1:0][DW-1:0] r_rem   [1:QW];
    logic [LANES-1:0][QW-1:0] r_quot  [1:QW];
    logic [VW-1:0]            r_div   [1:QW];
    logic [SW-1:0]            r_side  [1:QW];

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_stage
            localparam int B = QW - 1 - j;

            logic                     s_valid;
            logic [LANES-1:0][DW-1:0] s_rem;
            logic [LANES-1:0][QW-1:0] s_quot;
            logic [VW-1:0]            s_div;
            logic [SW-1:0]            s_side;
            logic [LANES-1:0][DW-1:0] n_rem;
            logic [LANES-1:0][QW-1:0] n_quot;
            logic [CW-1:0]            trial;

            if (j == 0) begin : g_first
                assign s_valid = i_valid;
                assign s_rem   = i_dividend;
                assign s_quot  = '0;
                assign s_div   = i_divisor;
                assign s_side  = i_side;
            end else begin : g_next
                assign s_valid = r_valid[j];
                assign s_rem   = r_rem[j];
                assign s_quot  = r_quot[j];
                assign s_div   = r_div[j];
                assign s_side  = r_side[j];
            end

            // One compare and subtract per lane at this quotient bit.
            assign trial = CW'(s_div) << B;

            always_comb begin
                n_rem  = s_rem;
                n_quot = s_quot;
                for (int l = 0; l < LANES; l++) begin
                    if (CW'(s_rem[l]) >= trial) begin
                        n_rem[l]     = DW'(CW'(s_rem[l]) - trial);
                        n_quot[l][B] = 1'b1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j+1] <= 1'b0;
                end else if (i_en) begin
                    r_valid[j+1] <= s_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1]  <= n_rem;
                    r_quot[j+1] <= n_quot;
                    r_div[j+1]  <= s_div;
                    r_side[j+1] <= s_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[QW];
    assign o_quot  = r_quot[QW];
    assign o_side  = r_side[QW];

endmodule

>>> rtl/dcp_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_sqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage,
// giving floor(sqrt(radicand)).
// ----------------------------------------------------------------------------
module dcp_sqrt_pipe #(
    parameter int IW = 66,
    parameter int RW = 33,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [IW-1:0] i_radicand,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [RW-1:0] o_root,
    output logic [SW-1:0] o_side
);

    localparam int TW = IW + 2;

    logic          r_valid [1:RW];
    logic [TW-1:0] r_rem   [1:RW];
    logic [RW-1:0] r_root  [1:RW];
    logic [SW-1:0] r_side  [1:RW];

    genvar j;
    generate
        for (j = 0; j < RW; j++) begin : g_stage
            localparam int B = RW - 1 - j;

            logic          s_valid;
            logic [TW-1:0] s_rem;
            logic [RW-1:0] s_root;
            logic [SW-1:0] s_side;
            logic [TW-1:0] term;
            logic [TW-1:0] n_rem;
            logic [RW-1:0] n_root;

            if (j == 0) begin : g_first
                assign s_valid = i_valid;
                assign s_rem   = TW'(i_radicand);
                assign s_root  = '0;
                assign s_side  = i_side;
            end else begin : g_next
                assign s_valid = r_valid[j];
                assign s_rem   = r_rem[j];
                assign s_root  = r_root[j];
                assign s_side  = r_side[j];
            end

            // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B).
            assign term = (TW'(s_root) << (B + 1)) | (TW'(1) << (2 * B));

            always_comb begin
                n_rem  = s_rem;
                n_root = s_root;
                if (s_rem >= term) begin
                    n_rem     = s_rem - term;
                    n_root[B] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j+1] <= 1'b0;
                end else if (i_en) begin
                    r_valid[j+1] <= s_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1]  <= n_rem;
                    r_root[j+1] <= n_root;
                    r_side[j+1] <= s_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];

endmodule

>>> rtl/dcp_corr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_corr
// Final three stages: error along each axis, per-particle correction, and
// the saturated position update into the output register.
// ----------------------------------------------------------------------------
module dcp_corr #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  dcp_pkg::t_cor                      i_cor,
    input  logic [2:0][FRAC_BITS:0]            i_nm,
    output logic                               o_valid,
    output dcp_pkg::t_out                      o_data
);
    import dcp_pkg::*;

    localparam int EP_W = MAG_W + FRAC_BITS + 1;
    localparam int DP_W = MAG_W + GAIN_W;

    logic                    r_c1_v, r_c2_v, r_c3_v;
    t_cor                    r_c1_cor, r_c2_cor;
    logic [2:0][MAG_W-1:0]   r_c1_em;
    logic [2:0][DELTA_W-1:0] r_c2_da, r_c2_db;
    t_out                    r_c3_out;

    logic [2:0][MAG_W-1:0]          n_em;
    logic [2:0][DELTA_W-1:0]        n_da, n_db;
    logic signed [2:0][POS_W-1:0]   n_na, n_nb;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi, lo;
        hi = WIDE_W'(2147483647);
        lo = -WIDE_W'(2147483647) - WIDE_W'(1);
        if (v > hi) begin
            return POS_W'(hi);
        end else if (v < lo) begin
            return POS_W'(lo);
        end
        return POS_W'(v);
    endfunction

    // Stage one: error magnitude along each axis.
    always_comb begin
        logic [EP_W-1:0] prod;
        for (int k = 0; k < 3; k++) begin
            prod    = EP_W'(i_cor.cmag) * EP_W'(i_nm[k]);
            n_em[k] = MAG_W'(prod >> FRAC_BITS);
        end
    end

    // Stage two: scale by each particle's gain.
    always_comb begin
        logic [DP_W-1:0] pa, pb;
        for (int k = 0; k < 3; k++) begin
            pa      = DP_W'(r_c1_em[k]) * DP_W'(r_c1_cor.ga);
            pb      = DP_W'(r_c1_em[k]) * DP_W'(r_c1_cor.gb);
            n_da[k] = DELTA_W'(pa >> GAIN_FRAC);
            n_db[k] = DELTA_W'(pb >> GAIN_FRAC);
        end
    end

    // Stage three: apply signed corrections and saturate; fixed pairs keep their positions.
    always_comb begin
        logic                     neg;
        logic signed [WIDE_W-1:0] pa, pb, sa, sb;
        for (int k = 0; k < 3; k++) begin
            neg = r_c2_cor.dneg[k] ^ r_c2_cor.cneg;
            pa  = WIDE_W'(r_c2_cor.pos_a[k]);
            pb  = WIDE_W'(r_c2_cor.pos_b[k]);
            sa  = neg ? -$signed({2'b00, r_c2_da[k]}) : $signed({2'b00, r_c2_da[k]});
            sb  = neg ? -$signed({2'b00, r_c2_db[k]}) : $signed({2'b00, r_c2_db[k]});
            if (r_c2_cor.fixed) begin
                n_na[k] = r_c2_cor.pos_a[k];
                n_nb[k] = r_c2_cor.pos_b[k];
            end else begin
                n_na[k] = sat_pos(pa - sa);
                n_nb[k] = sat_pos(pb + sb);
            end
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
            r_c3_v <= 1'b0;
        end else if (i_en) begin
            r_c1_v <= i_valid;
            r_c2_v <= r_c1_v;
            r_c3_v <= r_c2_v;
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1_cor         <= i_cor;
            r_c1_em          <= n_em;
            r_c2_cor         <= r_c1_cor;
            r_c2_da          <= n_da;
            r_c2_db          <= n_db;
            r_c3_out.new_a_x <= n_na[0];
            r_c3_out.new_a_y <= n_na[1];
            r_c3_out.new_a_z <= n_na[2];
            r_c3_out.new_b_x <= n_nb[0];
            r_c3_out.new_b_y <= n_nb[1];
            r_c3_out.new_b_z <= n_nb[2];
        end
    end

    assign o_valid = r_c3_v;
    assign o_data  = r_c3_out;

endmodule

>>> rtl/distance_constraint_projection_core.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while the output is not stalled; the gain divider, the square root and the
// direction divider each resolve one bit per pipeline stage.
// A stalled output holds the whole pipeline in place.
// Reset (synchronous, active low) clears all valid bits and sets stiffness to full.
// ----------------------------------------------------------------------------
// distance_constraint_projection_core
// Projects one distance constraint between two particles per transaction.
// ----------------------------------------------------------------------------
module distance_constraint_projection_core #(
    parameter int FRAC_BITS = dcp_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dcp_pkg::STIFF_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  dcp_pkg::t_in                 i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output dcp_pkg::t_out                o_out_data
);
    import dcp_pkg::*;

    localparam int ND_W = MAG_W + FRAC_BITS;

    logic                en;
    logic [STIFF_W-1:0]  r_stiff;

    // Stage one: differences, magnitudes and gain numerators.
    logic                     r_p1_v;
    t_pre                     r_p1_side, n_p1_side;
    logic [1:0][PROD_W-1:0]   r_p1_prod, n_p1_prod;
    logic [WSUM_W-1:0]        r_p1_wsum, n_p1_wsum;

    // Gain divider outputs.
    logic                     g_v;
    logic [1:0][GAIN_W-1:0]   g_quot;
    t_pre                     g_side;

    // Squares and sum.
    logic                     r_p2_v, r_p3_v;
    logic [2:0][SQ_W-1:0]     r_p2_sq;
    t_sq                      r_p2_side, r_p3_side;
    logic [SQ_W-1:0]          r_p3_sum;

    // Square root outputs.
    logic                     s_v;
    logic [ROOT_W-1:0]        s_root;
    t_sq                      s_side;

    // Error and direction divider inputs.
    logic                     r_p4_v;
    t_cor                     r_p4_cor, n_p4_cor;
    logic [ROOT_W-1:0]        r_p4_dist, n_p4_dist;
    logic [2:0][ND_W-1:0]     r_p4_num, n_p4_num;

    // Direction divider outputs.
    logic                     d_v;
    logic [2:0][FRAC_BITS:0]  d_quot;
    t_cor                     d_side;

    // The pipeline advances unless a finished result is waiting.
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Stiffness register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= STIFF_RESET;
        end else if (i_cfg_we) begin
            r_stiff <= i_cfg_data;
        end
    end

    // Stage one logic.
    always_comb begin
        t_pos [2:0]          pa, pb;
        logic [MAG_W-1:0]    diff;
        pa = {i_in_data.pos_a_x, i_in_data.pos_a_y, i_in_data.pos_a_z};
        pb = {i_in_data.pos_b_x, i_in_data.pos_b_y, i_in_data.pos_b_z};
        n_p1_side.pos_a = {pa[0], pa[1], pa[2]};
        n_p1_side.pos_b = {pb[0], pb[1], pb[2]};
        for (int k = 0; k < 3; k++) begin
            diff = {n_p1_side.pos_a[k][POS_W-1], n_p1_side.pos_a[k]}
                 - {n_p1_side.pos_b[k][POS_W-1], n_p1_side.pos_b[k]};
            n_p1_side.dneg[k] = diff[MAG_W-1];
            n_p1_side.dmag[k] = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
        end
        n_p1_side.rest  = i_in_data.rest_length;
        n_p1_wsum       = WSUM_W'(i_in_data.inv_mass_a) + WSUM_W'(i_in_data.inv_mass_b);
        n_p1_side.fixed = (n_p1_wsum == '0);
        n_p1_prod[0]    = PROD_W'(r_stiff) * PROD_W'(i_in_data.inv_mass_a);
        n_p1_prod[1]    = PROD_W'(r_stiff) * PROD_W'(i_in_data.inv_mass_b);
    end

    // Error, clamped distance and direction numerators.
    always_comb begin
        logic [ROOT_W-1:0] clamped;
        logic [C_W-1:0]    c;
        clamped = (s_root == '0) ? ROOT_W'(1) : s_root;
        c       = C_W'(clamped) - C_W'(s_side.pre.rest);
        n_p4_dist      = clamped;
        n_p4_cor.pos_a = s_side.pre.pos_a;
        n_p4_cor.pos_b = s_side.pre.pos_b;
        n_p4_cor.dneg  = s_side.pre.dneg;
        n_p4_cor.cneg  = c[C_W-1];
        n_p4_cor.cmag  = MAG_W'(c[C_W-1] ? (~c + C_W'(1)) : c);
        n_p4_cor.ga    = s_side.ga;
        n_p4_cor.gb    = s_side.gb;
        n_p4_cor.fixed = s_side.pre.fixed;
        for (int k = 0; k < 3; k++) begin
            n_p4_num[k] = ND_W'(s_side.pre.dmag[k]) << FRAC_BITS;
        end
    end

    // Valid bits of the stages kept here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else if (en) begin
            r_p1_v <= i_in_valid;
            r_p2_v <= g_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= s_v;
        end
    end

    // Payload registers of the stages kept here.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_side    <= n_p1_side;
            r_p1_prod    <= n_p1_prod;
            r_p1_wsum    <= n_p1_wsum;
            r_p2_side.pre <= g_side;
            r_p2_side.ga <= g_quot[0];
            r_p2_side.gb <= g_quot[1];
            for (int k = 0; k < 3; k++) begin
                r_p2_sq[k] <= SQ_W'(g_side.dmag[k]) * SQ_W'(g_side.dmag[k]);
            end
            r_p3_side    <= r_p2_side;
            r_p3_sum     <= r_p2_sq[0] + r_p2_sq[1] + r_p2_sq[2];
            r_p4_cor     <= n_p4_cor;
            r_p4_dist    <= n_p4_dist;
            r_p4_num     <= n_p4_num;
        end
    end

    // Per-particle gains: stiffness * w / (wa + wb).
    dcp_div_pipe #(
        .LANES (2),
        .DW    (PROD_W),
        .VW    (WSUM_W),
        .QW    (GAIN_W),
        .SW    ($bits(t_pre))
    ) u_gain_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_p1_v),
        .i_dividend (r_p1_prod),
        .i_divisor  (r_p1_wsum),
        .i_side     (r_p1_side),
        .o_valid    (g_v),
        .o_quot     (g_quot),
        .o_side     (g_side)
    );

    // Separation length.
    dcp_sqrt_pipe #(
        .IW (SQ_W),
        .RW (ROOT_W),
        .SW ($bits(t_sq))
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_p3_v),
        .i_radicand (r_p3_sum),
        .i_side     (r_p3_side),
        .o_valid    (s_v),
        .o_root     (s_root),
        .o_side     (s_side)
    );

    // Unit direction magnitudes, one lane per axis.
    dcp_div_pipe #(
        .LANES (3),
        .DW    (ND_W),
        .VW    (ROOT_W),
        .QW    (FRAC_BITS + 1),
        .SW    ($bits(t_cor))
    ) u_dir_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_p4_v),
        .i_dividend (r_p4_num),
        .i_divisor  (r_p4_dist),
        .i_side     (r_p4_cor),
        .o_valid    (d_v),
        .o_quot     (d_quot),
        .o_side     (d_side)
    );

    // Corrections and output register.
    dcp_corr #(
        .FRAC_BITS (FRAC_BITS)
    ) u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_v),
        .i_cor   (d_side),
        .i_nm    (d_quot),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule
